### design/jsfe_pkg.sv
// ----------------------------------------------------------------------------
// jsfe_pkg
// Shared types and constants of the JSON string field extractor: character
// codes, scan phases, result kinds and the result item layout.
// ----------------------------------------------------------------------------
package jsfe_pkg;

	// Key window geometry
	localparam int MAX_KEY_BYTES = 8;
	localparam int WINDOW_DEPTH  = MAX_KEY_BYTES + 2;
	localparam int KEY_LEN_W     = 4;

	// Output queue geometry
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// Character codes
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_KEY_TEXT    = 2'd0,
		REG_KEY_LENGTH  = 2'd1,
		REG_VALUE_LIMIT = 2'd2
	} reg_index_t;

	// Scan phases
	typedef enum logic [2:0] {
		PH_SEARCH      = 3'd0,
		PH_AFTER_KEY   = 3'd1,
		PH_AFTER_COLON = 3'd2,
		PH_VALUE       = 3'd3,
		PH_ESCAPE      = 3'd4,
		PH_DRAIN       = 3'd5
	} phase_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_FOUND   = 2'd1,
		KIND_MISSING = 2'd2
	} kind_t;

	// One result item
	typedef struct packed {
		logic [7:0] value_byte;
		kind_t      result_kind;
		logic       run_last;
	} result_t;

	// Results of one processed text byte, in delivery order
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_req_t;

endpackage

### design/jsfe_out_fifo.sv
// ----------------------------------------------------------------------------
// jsfe_out_fifo
// Small result queue: takes up to two result items per cycle in order and
// hands out one per transfer on the master side.
// ----------------------------------------------------------------------------
module jsfe_out_fifo
	import jsfe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  push_req_t push,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output result_t   out_item
);

	result_t              entry_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] count_q;
	logic                 pop;

	// Room for the two results a byte can cause
	assign room      = (count_q <= OUT_CNT_W'(OUT_DEPTH - 2));
	assign out_valid = (count_q != '0);
	assign out_item  = entry_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_q + OUT_PTR_W'(1)] <= push.second;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			count_q <= count_q + OUT_CNT_W'(push.count) - OUT_CNT_W'(pop);
		end
	end

endmodule

### design/json_string_field_extractor_core.sv
// ----------------------------------------------------------------------------
// json_string_field_extractor_core
// Scans a flat JSON text one byte per transfer, finds the first quoted copy of
// the configured key and streams out its decoded string value, closed by a
// found or not-found result.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata text_byte, tlast text_end
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata value_byte,
//                                                tuser result_kind, tlast run_last
//  cfg       in   cfg_wr_en                      cfg_index, cfg_wr_data
//
//  One text byte per cycle sustained while the result queue has room. A byte
//  is held in the input register and then decoded into the four-entry result
//  queue, from which its results are offered on m_axis. The queue takes a
//  byte only when two entries are free; a byte that closes a value can cause
//  two results, and an output stall backs up into s_axis_tready through that
//  check. Reset clears phase, count, key window and queue at once.
// ----------------------------------------------------------------------------
module json_string_field_extractor_core
	import jsfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,   // text_end
	// stream out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] value_byte
	output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
	output logic        m_axis_tlast,   // run_last
	// configuration
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wr_data
);

	// Configuration registers
	logic [63:0]          key_text_q;
	logic [KEY_LEN_W-1:0] key_length_q;
	logic [7:0]           value_limit_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       fire_s1;

	// Scan state
	phase_t     phase_q;
	logic [7:0] value_count_q;
	logic [7:0] win_q [WINDOW_DEPTH];

	// Decode results
	logic [7:0]           win_new [WINDOW_DEPTH];
	logic                 match_len [MAX_KEY_BYTES + 1];
	logic [KEY_LEN_W-1:0] key_len_eff;
	logic                 key_hit;
	logic                 nz;
	logic [7:0]           cnt_inc;
	logic                 limit_hit;
	logic                 emit_val;
	logic [7:0]           val_b;
	logic                 close;
	kind_t                close_kind;
	phase_t               phase_mid;
	logic                 shift_win;
	logic                 zero_cnt;

	// Next state
	phase_t     phase_d;
	logic [7:0] count_d;
	logic       clear_text;

	// Queue
	push_req_t push;
	logic      room;
	result_t   out_item;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_text_q    <= '0;
			key_length_q  <= KEY_LEN_W'(1);
			value_limit_q <= 8'd31;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_KEY_TEXT:    key_text_q    <= cfg_wr_data;
				REG_KEY_LENGTH:  key_length_q  <= cfg_wr_data[KEY_LEN_W-1:0];
				REG_VALUE_LIMIT: value_limit_q <= cfg_wr_data[7:0];
				default: ;
			endcase
		end
	end

	// Input register
	assign fire_s1       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	// Window after shifting in the current byte, and key compare per length
	always_comb begin
		win_new[0] = byte_s1;
		for (int k = 1; k < WINDOW_DEPTH; k++) begin
			win_new[k] = win_q[k-1];
		end
		for (int l = 0; l <= MAX_KEY_BYTES; l++) begin
			match_len[l] = (win_new[0] == CH_QUOTE) && (win_new[l+1] == CH_QUOTE);
			for (int i = 0; i < l; i++) begin
				match_len[l] = match_len[l] && (win_new[l-i] == key_text_q[8*i +: 8]);
			end
		end
	end

	assign key_len_eff = (key_length_q > KEY_LEN_W'(MAX_KEY_BYTES)) ?
	                     KEY_LEN_W'(MAX_KEY_BYTES) : key_length_q;
	assign key_hit     = match_len[key_len_eff];
	assign nz          = (byte_s1 != 8'd0);
	assign cnt_inc     = (value_count_q == 8'hFF) ? value_count_q : value_count_q + 8'd1;
	assign limit_hit   = (cnt_inc >= value_limit_q);

	// Decode the byte against the current phase
	always_comb begin
		emit_val   = 1'b0;
		val_b      = '0;
		close      = 1'b0;
		close_kind = KIND_MISSING;
		phase_mid  = phase_q;
		shift_win  = 1'b0;
		zero_cnt   = 1'b0;
		unique case (phase_q)
			PH_SEARCH: begin
				if (nz) begin
					shift_win = 1'b1;
					if (key_hit) begin
						phase_mid = PH_AFTER_KEY;
					end
				end
			end
			PH_AFTER_KEY: begin
				if (nz) begin
					if (byte_s1 == CH_COLON) begin
						phase_mid = PH_AFTER_COLON;
					end else if (byte_s1 != CH_SPACE && byte_s1 != CH_TAB) begin
						close = 1'b1;
					end
				end
			end
			PH_AFTER_COLON: begin
				if (nz) begin
					if (byte_s1 == CH_QUOTE) begin
						phase_mid = PH_VALUE;
						zero_cnt  = 1'b1;
						if (value_limit_q == 8'd0) begin
							close      = 1'b1;
							close_kind = KIND_FOUND;
						end
					end else if (byte_s1 != CH_SPACE && byte_s1 != CH_TAB) begin
						close = 1'b1;
					end
				end
			end
			PH_VALUE: begin
				if (nz) begin
					if (byte_s1 == CH_QUOTE) begin
						close      = 1'b1;
						close_kind = KIND_FOUND;
					end else if (byte_s1 == CH_BSLASH) begin
						phase_mid = PH_ESCAPE;
					end else begin
						emit_val = 1'b1;
						val_b    = byte_s1;
						if (limit_hit) begin
							close      = 1'b1;
							close_kind = KIND_FOUND;
						end
					end
				end
			end
			PH_ESCAPE: begin
				if (nz) begin
					phase_mid = PH_VALUE;
					if (byte_s1 != CH_R) begin
						emit_val = 1'b1;
						val_b    = (byte_s1 == CH_N) ? CH_LF :
						           (byte_s1 == CH_T) ? CH_TAB : byte_s1;
						if (limit_hit) begin
							close      = 1'b1;
							close_kind = KIND_FOUND;
						end
					end
				end
			end
			default: ;
		endcase

		// Close an unfinished field at the end of the text or at a zero byte
		if (phase_q != PH_DRAIN && phase_q <= PH_ESCAPE && !close && (end_s1 || !nz)) begin
			close = 1'b1;
			if (phase_mid == PH_ESCAPE) begin
				emit_val   = 1'b1;
				val_b      = CH_BSLASH;
				close_kind = KIND_FOUND;
			end else if (phase_mid == PH_VALUE) begin
				close_kind = KIND_FOUND;
			end
		end
	end

	// Next phase and count
	always_comb begin
		phase_d    = phase_q;
		count_d    = value_count_q;
		clear_text = 1'b0;
		if (phase_q == PH_DRAIN || phase_q > PH_ESCAPE) begin
			clear_text = end_s1;
		end else if (close) begin
			if (end_s1) begin
				clear_text = 1'b1;
			end else begin
				phase_d = PH_DRAIN;
			end
		end else begin
			phase_d = phase_mid;
			if (zero_cnt) begin
				count_d = 8'd0;
			end else if (emit_val) begin
				count_d = cnt_inc;
			end
		end
		if (clear_text) begin
			phase_d = PH_SEARCH;
			count_d = 8'd0;
		end
	end

	// Result items in delivery order
	always_comb begin
		push = '0;
		if (fire_s1) begin
			if (emit_val) begin
				push.first.value_byte  = val_b;
				push.first.result_kind = KIND_BYTE;
				push.first.run_last    = 1'b0;
				if (close) begin
					push.second.result_kind = close_kind;
					push.second.run_last    = 1'b1;
					push.count              = 2'd2;
				end else begin
					push.count = 2'd1;
				end
			end else if (close) begin
				push.first.result_kind = close_kind;
				push.first.run_last    = 1'b1;
				push.count             = 2'd1;
			end
		end
	end

	// Update scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SEARCH;
			value_count_q <= '0;
			for (int k = 0; k < WINDOW_DEPTH; k++) begin
				win_q[k] <= '0;
			end
		end else if (fire_s1) begin
			phase_q       <= phase_d;
			value_count_q <= count_d;
			if (clear_text) begin
				for (int k = 0; k < WINDOW_DEPTH; k++) begin
					win_q[k] <= '0;
				end
			end else if (shift_win) begin
				for (int k = 0; k < WINDOW_DEPTH; k++) begin
					win_q[k] <= win_new[k];
				end
			end
		end
	end

	// Result queue
	jsfe_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item)
	);

	assign m_axis_tdata = out_item.value_byte;
	assign m_axis_tuser = out_item.result_kind;
	assign m_axis_tlast = out_item.run_last;

	// Checks
	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && end_s1) |=> (phase_q == PH_SEARCH && value_count_q == 8'd0))
		else $error("text end did not restart the scan");

	a_drain_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && phase_q == PH_DRAIN) |-> (push.count == 2'd0))
		else $error("result pushed while draining");

	a_bytes_in_value: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0 && push.first.result_kind == KIND_BYTE)
		|-> (phase_q == PH_VALUE || phase_q == PH_ESCAPE))
		else $error("value byte outside a value");

	a_close_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != KIND_BYTE) |-> (m_axis_tlast && m_axis_tdata == 8'd0))
		else $error("closing result badly formed");

endmodule
